// ===== hdl/png_chunk_deframer_crc_macros.svh =====
// Assertion macros used by the PNG chunk deframer parser.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef PNG_CHUNK_DEFRAMER_CRC_MACROS_SVH
`define PNG_CHUNK_DEFRAMER_CRC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pcd_pkg.sv =====
// Package for the PNG chunk deframer: phase and status codes, the item and
// result types, the PNG signature and the byte-wise CRC-32 update.
// No dependencies.
package pcd_pkg;

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;
  localparam logic [2:0] PH_STOP = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADCRC = 2'd1;
  localparam logic [1:0] ST_BADSIG = 2'd2;

  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [15:0] CNT_MAX   = 16'hFFFF;

  localparam int unsigned TDATA_W = 112;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } pcd_item_t;

  typedef struct packed {
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [15:0] chunk_number;
    logic [31:0] computed_crc;
    logic [1:0]  status;
    logic        is_end;
  } pcd_result_t;

  // The eight bytes of the PNG file signature.
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4e;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0d;
      3'd5: v = 8'h0a;
      3'd6: v = 8'h1a;
      3'd7: v = 8'h0a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // One byte of the reflected CRC-32, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/pcd_in_stage.sv =====
// Input register of the PNG chunk deframer: holds one byte transaction
// until the parser takes it. Depends on pcd_pkg.
module pcd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tuser,
  input  logic              take,
  output logic              item_valid,
  output pcd_pkg::pcd_item_t item
);
  import pcd_pkg::*;

  logic      valid_r, valid_nxt;
  pcd_item_t item_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_byte     <= in_tdata;
      item_r.start_of_file <= in_tuser;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/pcd_parser.sv =====
// Chunk parser of the PNG chunk deframer: signature check, field framing,
// CRC-32 and the chunk counter. Depends on pcd_pkg and the macro header.
`include "png_chunk_deframer_crc_macros.svh"
module pcd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  pcd_pkg::pcd_item_t  item,
  input  logic                out_room,
  output logic                take,
  output logic                res_valid,
  output pcd_pkg::pcd_result_t res
);
  import pcd_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] typ_r, typ_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rcv_r, rcv_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic [2:0]  eff_phase;
  logic [31:0] eff_pos, eff_len, eff_typ, eff_crc, eff_rcv;
  logic [15:0] eff_cnt;
  logic [31:0] pos_inc, rcv_shift, crc_fin;
  logic [7:0]  b;
  logic        res_hit, bad;

  // A start-of-file byte sees the reset state.
  assign b         = item.data_byte;
  assign eff_phase = item.start_of_file ? PH_SIG   : phase_r;
  assign eff_pos   = item.start_of_file ? 32'd0    : pos_r;
  assign eff_len   = item.start_of_file ? 32'd0    : len_r;
  assign eff_typ   = item.start_of_file ? 32'd0    : typ_r;
  assign eff_crc   = item.start_of_file ? CRC_INIT : crc_r;
  assign eff_rcv   = item.start_of_file ? 32'd0    : rcv_r;
  assign eff_cnt   = item.start_of_file ? 16'd0    : cnt_r;
  assign pos_inc   = eff_pos + 32'd1;
  assign rcv_shift = {eff_rcv[23:0], b};
  assign crc_fin   = ~eff_crc;

  always_comb begin
    phase_nxt = eff_phase;
    pos_nxt   = eff_pos;
    len_nxt   = eff_len;
    typ_nxt   = eff_typ;
    crc_nxt   = eff_crc;
    rcv_nxt   = eff_rcv;
    cnt_nxt   = eff_cnt;
    res_hit   = 1'b0;
    bad       = 1'b0;
    res       = '0;
    case (eff_phase)
      PH_SIG: begin
        if (b != sig_byte(eff_pos[2:0])) begin
          phase_nxt  = PH_STOP;
          res_hit    = 1'b1;
          res.status = ST_BADSIG;
          res.is_end = 1'b1;
        end else begin
          pos_nxt = pos_inc;
          if (pos_inc >= 32'd8) begin
            phase_nxt = PH_LEN;
            pos_nxt   = 32'd0;
          end
        end
      end
      PH_LEN: begin
        len_nxt = {eff_len[23:0], b};
        pos_nxt = pos_inc;
        if (pos_inc >= 32'd4) begin
          phase_nxt = PH_TYPE;
          pos_nxt   = 32'd0;
          crc_nxt   = CRC_INIT;
        end
      end
      PH_TYPE: begin
        typ_nxt = {eff_typ[23:0], b};
        crc_nxt = crc_byte(eff_crc, b);
        pos_nxt = pos_inc;
        if (pos_inc >= 32'd4) begin
          pos_nxt   = 32'd0;
          phase_nxt = (eff_len == 32'd0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_nxt = crc_byte(eff_crc, b);
        pos_nxt = pos_inc;
        if (pos_inc == eff_len) begin
          pos_nxt   = 32'd0;
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        rcv_nxt = rcv_shift;
        pos_nxt = pos_inc;
        if (pos_inc >= 32'd4) begin
          pos_nxt          = 32'd0;
          cnt_nxt          = (eff_cnt < CNT_MAX) ? eff_cnt + 16'd1 : eff_cnt;
          bad              = (crc_fin != rcv_shift);
          res_hit          = 1'b1;
          res.chunk_type   = eff_typ;
          res.chunk_length = eff_len;
          res.chunk_number = cnt_nxt;
          res.computed_crc = crc_fin;
          res.status       = bad ? ST_BADCRC : ST_OK;
          res.is_end       = bad || (eff_typ == TYPE_IEND);
          phase_nxt        = res.is_end ? PH_STOP : PH_LEN;
          len_nxt          = res.is_end ? eff_len : 32'd0;
        end
      end
      default: begin
        // Stopped, and the unused phase codes: the byte is dropped.
      end
    endcase
  end

  // A byte with no result never waits on the output side.
  assign take      = item_valid && (!res_hit || out_room);
  assign res_valid = take && res_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      pos_r   <= 32'd0;
      len_r   <= 32'd0;
      typ_r   <= 32'd0;
      crc_r   <= CRC_INIT;
      rcv_r   <= 32'd0;
      cnt_r   <= 16'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      typ_r   <= typ_nxt;
      crc_r   <= crc_nxt;
      rcv_r   <= rcv_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `PCD_ASSERT_NEXT(a_stop_holds, phase_r == PH_STOP && !(take && item.start_of_file), phase_r == PH_STOP, "parser left the stopped phase without a start of file")
  `PCD_ASSERT_SAME(a_err_ends, res_valid, res.is_end || res.status == ST_OK, "error result does not end parsing")
  `PCD_ASSERT_SAME(a_field_pos, phase_r == PH_LEN || phase_r == PH_TYPE || phase_r == PH_CRC, pos_r < 32'd4, "byte position beyond a four-byte field")

endmodule

// ===== hdl/pcd_out_stage.sv =====
// Output register of the PNG chunk deframer: holds one result transaction
// until the sink takes it. Depends on pcd_pkg.
module pcd_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  pcd_pkg::pcd_result_t        load_res,
  output logic                        room,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pcd_pkg::TDATA_W-1:0] out_tdata,
  output logic [1:0]                  out_tuser,
  output logic                        out_tlast
);
  import pcd_pkg::*;

  logic        valid_r, valid_nxt;
  pcd_result_t res_r;

  assign room      = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.computed_crc, res_r.chunk_number,
                       res_r.chunk_length, res_r.chunk_type};
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.is_end;

endmodule

// ===== hdl/png_chunk_deframer_crc.sv =====
// PNG chunk deframer with CRC-32 check. Takes one file byte per transaction
// (in_tuser marks the first byte of a file), checks the signature, frames
// each chunk and gives one result on its last CRC byte or on a bad signature
// byte: type, length, chunk number and computed CRC in out_tdata, status in
// out_tuser, and out_tlast high when parsing stops (IEND, CRC mismatch or
// bad signature). One byte is taken every cycle while none waits, through
// the input and result registers. A byte that produces a result waits only
// while the result register still holds an untaken result; other bytes never
// wait. Depends on pcd_pkg, pcd_in_stage, pcd_parser and pcd_out_stage.
module png_chunk_deframer_crc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tuser,   // [0] start_of_file
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [31:0] chunk_type, [63:32] chunk_length, [79:64] chunk_number,
  // [111:80] computed_crc
  output logic [pcd_pkg::TDATA_W-1:0] out_tdata,
  output logic [1:0]                  out_tuser,  // [1:0] status
  output logic                        out_tlast   // is_end
);
  import pcd_pkg::*;

  logic        take;
  logic        item_valid;
  pcd_item_t   item;
  logic        room;
  logic        res_valid;
  pcd_result_t res;

  pcd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  pcd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_room   (room),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  pcd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .load_res   (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
